FILE: src/sha1_pkg.sv
// Shared types, constants and codes for the SHA-1 hash core.
package sha1_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } sha1_req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } sha1_rsp_type;

   typedef logic [0:4][31:0]  sha1_word5_type;
   typedef logic [0:15][31:0] sha1_block_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } sha1_state_type;

   typedef struct packed {
      logic       shift_byte;
      logic       shift_word;
      logic [7:0] byte_value;
   } sha1_sched_ctl_type;

   localparam sha1_word5_type CHAIN_INIT = {
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [31:0] K_ROUND0 = 32'h5A827999;
   localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

   localparam logic [6:0] ROUND_GROUP1 = 7'd20;
   localparam logic [6:0] ROUND_GROUP2 = 7'd40;
   localparam logic [6:0] ROUND_GROUP3 = 7'd60;
   localparam logic [6:0] ROUND_LAST   = 7'd79;

   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [5:0] POS_LAST   = 6'd63;
   localparam logic [5:0] POS_LENGTH = 6'd56;
   localparam logic [63:0] BITS_PER_BYTE = 64'd8;

   localparam logic [2:0] WORD_IDX_0    = 3'd0;
   localparam logic [2:0] WORD_IDX_1    = 3'd1;
   localparam logic [2:0] WORD_IDX_2    = 3'd2;
   localparam logic [2:0] WORD_IDX_3    = 3'd3;
   localparam logic [2:0] WORD_IDX_LAST = 3'd4;

endpackage

FILE: src/sha1_round.sv
// One SHA-1 compression round, shared across all 80 rounds.
module sha1_round (
   input  sha1_pkg::sha1_word5_type vars,
   input  logic [31:0]              w,
   input  logic [6:0]               round_idx,
   output sha1_pkg::sha1_word5_type vars_next
);
   import sha1_pkg::*;

   logic [31:0] a, b, c, d, e;
   logic [31:0] f, k;

   assign a = vars[0];
   assign b = vars[1];
   assign c = vars[2];
   assign d = vars[3];
   assign e = vars[4];

   always_comb begin
      if (round_idx < ROUND_GROUP1) begin
         f = (b & c) | (~b & d);
         k = K_ROUND0;
      end else if (round_idx < ROUND_GROUP2) begin
         f = b ^ c ^ d;
         k = K_ROUND1;
      end else if (round_idx < ROUND_GROUP3) begin
         f = (b & c) | (b & d) | (c & d);
         k = K_ROUND2;
      end else begin
         f = b ^ c ^ d;
         k = K_ROUND3;
      end
   end

   assign vars_next[0] = {a[26:0], a[31:27]} + f + e + k + w;
   assign vars_next[1] = a;
   assign vars_next[2] = {b[1:0], b[31:2]};
   assign vars_next[3] = c;
   assign vars_next[4] = d;

endmodule

FILE: src/sha1_sched.sv
// Block buffer: byte-wise fill and word-wise message schedule expansion.
module sha1_sched (
   input  logic                         clock,
   input  sha1_pkg::sha1_sched_ctl_type ctl,
   output logic [31:0]                  w_cur
);
   import sha1_pkg::*;

   sha1_block_type w_ff, w_in;
   logic [31:0]    mix;

   assign mix = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];

   always_comb begin
      w_in = w_ff;
      if (ctl.shift_byte) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = {w_ff[i][23:0], w_ff[i+1][31:24]};
         end
         w_in[15] = {w_ff[15][23:0], ctl.byte_value};
      end else if (ctl.shift_word) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[15] = {mix[30:0], mix[31]};
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

   assign w_cur = w_ff[0];

endmodule

FILE: src/sha1_hash_core.sv
// SHA-1 hash core: sequencer, chaining value and digest output.
//
// Usage:
//   req channel: one transfer per message byte (has_byte = 1) or none
//   (has_byte = 0); last = 1 closes the message, any byte on it counts first.
//   An empty message is a single transfer with has_byte = 0 and last = 1.
//   rsp channel: five transfers per message, digest word 0 (most significant)
//   first, word_index 0..4, last_word set on word 4.
// Timing:
//   A byte that fills the 64-byte block starts the 80 rounds and the
//   chaining add, all on the single round unit. After last, padding shifts
//   in one byte per cycle up to the end of the block (one or two blocks,
//   each then compressed in turn), then the five digest words follow,
//   one per cycle while rsp_stall is low. req_stall is high whenever the
//   core is padding, compressing or holding digest words.
// Reset clears the message state and loads the initial chaining value. A
// stalled digest word is held until it is taken; the next message is not
// accepted until word 4 has been transferred.
module sha1_hash_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sha1_pkg::sha1_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sha1_pkg::sha1_rsp_type rsp_data
);
   import sha1_pkg::*;

   sha1_state_type     state_ff, state_in;
   logic [5:0]         pos_ff, pos_in;
   logic [63:0]        count_ff, count_in;
   logic               mark_ff, mark_in;
   logic               len_ff, len_in;
   logic               pad_ff, pad_in;
   logic [6:0]         round_ff, round_in;
   logic [2:0]         idx_ff, idx_in;
   sha1_word5_type     chain_ff, chain_in;
   sha1_word5_type     vars_ff, vars_in;
   sha1_word5_type     vars_next;
   sha1_sched_ctl_type sched_ctl;
   logic [31:0]        w_cur;
   logic               len_sel;

   sha1_sched u_sched (
      .clock (clock),
      .ctl   (sched_ctl),
      .w_cur (w_cur)
   );

   sha1_round u_round (
      .vars      (vars_ff),
      .w         (w_cur),
      .round_idx (round_ff),
      .vars_next (vars_next)
   );

   assign len_sel = mark_ff && (len_ff || (pos_ff == POS_LENGTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         count_ff <= '0;
         mark_ff  <= 1'b0;
         len_ff   <= 1'b0;
         pad_ff   <= 1'b0;
         round_ff <= '0;
         idx_ff   <= '0;
         chain_ff <= CHAIN_INIT;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
         mark_ff  <= mark_in;
         len_ff   <= len_in;
         pad_ff   <= pad_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      vars_ff <= vars_in;
   end

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      mark_in   = mark_ff;
      len_in    = len_ff;
      pad_in    = pad_ff;
      round_in  = round_ff;
      idx_in    = idx_ff;
      chain_in  = chain_ff;
      vars_in   = vars_ff;
      sched_ctl = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_data.has_byte) begin
                  sched_ctl.shift_byte = 1'b1;
                  sched_ctl.byte_value = req_data.data_byte;
                  pos_in   = pos_ff + 6'd1;
                  count_in = count_ff + BITS_PER_BYTE;
               end
               pad_in = req_data.last;
               if (req_data.has_byte && (pos_ff == POS_LAST)) begin
                  state_in = ST_ROUND;
                  vars_in  = chain_ff;
               end else if (req_data.last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            sched_ctl.shift_byte = 1'b1;
            if (!mark_ff) begin
               sched_ctl.byte_value = PAD_MARK;
               mark_in = 1'b1;
            end else if (len_sel) begin
               sched_ctl.byte_value = count_ff[63:56];
               len_in   = 1'b1;
               count_in = {count_ff[55:0], 8'h00};
            end else begin
               sched_ctl.byte_value = 8'h00;
            end
            pos_in = pos_ff + 6'd1;
            if (pos_ff == POS_LAST) begin
               state_in = ST_ROUND;
               vars_in  = chain_ff;
            end
         end
         ST_ROUND: begin
            sched_ctl.shift_word = 1'b1;
            vars_in = vars_next;
            if (round_ff == ROUND_LAST) begin
               round_in = '0;
               state_in = ST_ADD;
            end else begin
               round_in = round_ff + 7'd1;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 5; i++) begin
               chain_in[i] = chain_ff[i] + vars_ff[i];
            end
            if (len_ff) begin
               state_in = ST_OUT;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (idx_ff == WORD_IDX_LAST) begin
                  state_in = ST_IDLE;
                  idx_in   = '0;
                  chain_in = CHAIN_INIT;
                  count_in = '0;
                  pos_in   = '0;
                  mark_in  = 1'b0;
                  len_in   = 1'b0;
                  pad_in   = 1'b0;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      case (idx_ff)
         WORD_IDX_0:    rsp_data.digest_word = chain_ff[0];
         WORD_IDX_1:    rsp_data.digest_word = chain_ff[1];
         WORD_IDX_2:    rsp_data.digest_word = chain_ff[2];
         WORD_IDX_3:    rsp_data.digest_word = chain_ff[3];
         WORD_IDX_LAST: rsp_data.digest_word = chain_ff[4];
         default:       rsp_data.digest_word = chain_ff[0];
      endcase
      rsp_data.word_index = idx_ff;
      rsp_data.last_word  = (idx_ff == WORD_IDX_LAST);
   end

`ifndef SYNTHESIS
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while digest pending");

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.last_word) |=> !rsp_valid)
      else $error("digest output continued past last word");

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      round_ff <= ROUND_LAST)
      else $error("round counter out of range");

   a_round_only_in_round: assert property (@(posedge clock) disable iff (reset)
      (round_ff != 7'd0) |-> (state_ff == ST_ROUND))
      else $error("round counter active outside compression");
`endif

endmodule
